[rtl/core/lcs_pkg.sv]
// Shared types and constants for the Game of Life stencil stream.
`default_nettype none
package lcs_pkg;

    // Width of the configuration registers and of the register index.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    // Width of the row and column fields of a result.
    localparam int POS_W = 10;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

    // One classified item as it travels from the front to the back part.
    typedef struct packed {
        logic             cur;       // incoming cell, dead for pads and flush
        logic             top;       // cell two rows up, zero above the grid
        logic             mid;       // cell one row up, zero above the grid
        logic             col_zero;  // first column: window restarts
        logic             emit1;     // result for the cell up and to the left
        logic             emit2;     // extra result for the last column
        logic             flush;     // item belongs to the flush row
        logic [POS_W-1:0] row;       // row index of the emitted cells
        logic [POS_W-1:0] col;       // column index of the incoming item
    } t_entry;

endpackage
`default_nettype wire

[rtl/core/life_cell_stencil_stream.sv]
// Top level of the streaming Game of Life stencil: front part, queue and back part.
// A cell's result comes from the item below-right of it, which passes the line store
// read in the stage register, then the queue, then the output register.
// Throughput: one item per cycle unless the queue or the output stalls, except that a
// last-column item yields two results and the second one holds off the next item.
// Reset is synchronous and active low: counters, window, queue and valids clear and
// both size registers return to 1024; the line stores are not cleared.
`default_nettype none
module life_cell_stencil_stream #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lcs_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_op,
    input  wire logic                          i_cell_alive,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_next_alive,
    output logic [lcs_pkg::POS_W-1:0]          o_cell_row,
    output logic [lcs_pkg::POS_W-1:0]          o_cell_col,
    output logic                               o_frame_last,
    output logic                               o_run_last
);
    import lcs_pkg::*;

    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    t_entry front_entry;
    t_entry back_entry;

    // Front part: counters, line stores and classification.
    lcs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_cell_alive (i_cell_alive),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_entry      (front_entry)
    );

    // Queue between the two parts.
    lcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (back_entry)
    );

    // Back part: window, rule and results.
    lcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_entry      (back_entry),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_next_alive (o_next_alive),
        .o_cell_row   (o_cell_row),
        .o_cell_col   (o_cell_col),
        .o_frame_last (o_frame_last),
        .o_run_last   (o_run_last)
    );

endmodule
`default_nettype wire

[rtl/core/lcs_ram.sv]
// Generic simple dual-port RAM with a registered read port.
`default_nettype none
module lcs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/lcs_front.sv]
// Front part: configuration, raster counters, line stores and item classification.
`default_nettype none
module lcs_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lcs_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_op,
    input  wire logic                          i_cell_alive,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output lcs_pkg::t_entry                    o_entry
);
    import lcs_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int RCW = (RW > CFG_W) ? RW : CFG_W;
    localparam int CCW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
    localparam logic [RCW-1:0] ROWS_MAX = RCW'(MAX_ROWS);
    localparam logic [RCW-1:0] ROWS_MIN = RCW'(1);
    localparam logic [CCW-1:0] COLS_MAX = CCW'(MAX_COLS);
    localparam logic [CCW-1:0] COLS_MIN = CCW'(2);

    logic [CFG_W-1:0] r_grid_rows;
    logic [CFG_W-1:0] r_grid_cols;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;

    logic [RCW-1:0]        rows_cfg;
    logic [RCW-1:0]        rows_use;
    logic [CCW-1:0]        cols_cfg;
    logic [CCW-1:0]        cols_use;
    logic [CCW-1:0]        cols_last;
    logic                  flush;
    logic                  row_end;
    logic                  cur;
    logic                  accept;
    logic [RW+POS_W-1:0]   row_m1_ext;
    logic [CW+POS_W-1:0]   col_ext;

    // Stage register that waits for the line store read.
    logic             r_s_valid;
    logic [CW-1:0]    r_s_col;
    logic             r_s_cur;
    logic             r_s_ge1;
    logic             r_s_ge2;
    logic             r_s_colz;
    logic             r_s_end;
    logic             r_s_flush;
    logic [POS_W-1:0] r_s_row10;
    logic [POS_W-1:0] r_s_col10;

    logic [1:0] rd_data;
    logic       top;
    logic       mid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= CFG_W'(1024);
            r_grid_cols <= CFG_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                REG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the grid size to the supported range.
    always_comb begin
        rows_cfg = RCW'(r_grid_rows);
        cols_cfg = CCW'(r_grid_cols);
        if (rows_cfg < ROWS_MIN) begin
            rows_use = ROWS_MIN;
        end else if (rows_cfg > ROWS_MAX) begin
            rows_use = ROWS_MAX;
        end else begin
            rows_use = rows_cfg;
        end
        if (cols_cfg < COLS_MIN) begin
            cols_use = COLS_MIN;
        end else if (cols_cfg > COLS_MAX) begin
            cols_use = COLS_MAX;
        end else begin
            cols_use = cols_cfg;
        end
    end

    // Classify the incoming item from the raster position.
    assign cols_last  = cols_use - CCW'(1);
    assign flush      = RCW'(r_row) >= rows_use;
    assign row_end    = CCW'(r_col) >= cols_last;
    assign cur        = !flush && !i_op && i_cell_alive;
    assign row_m1_ext = {POS_W'(0), r_row} - (RW + POS_W)'(1);
    assign col_ext    = {POS_W'(0), r_col};

    // Handshake: the stage frees up when its item moves into the queue.
    assign o_push     = r_s_valid && !i_q_full;
    assign o_in_ready = !r_s_valid || o_push;
    assign accept     = i_in_valid && o_in_ready;

    // Raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= flush ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Stage register next to the line store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (accept) begin
            r_s_valid <= 1'b1;
        end else if (o_push) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_col   <= r_col;
            r_s_cur   <= cur;
            r_s_ge1   <= r_row != '0;
            r_s_ge2   <= {1'b0, r_row} >= (RW + 1)'(2);
            r_s_colz  <= r_col == '0;
            r_s_end   <= row_end;
            r_s_flush <= flush;
            r_s_row10 <= row_m1_ext[POS_W-1:0];
            r_s_col10 <= col_ext[POS_W-1:0];
        end
    end

    // Both line stores share one RAM: bit 1 is two rows up, bit 0 one row up.
    lcs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (o_push),
        .i_waddr (r_s_col),
        .i_wdata ({mid, r_s_cur}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    // Rows above the grid read as dead.
    assign top = r_s_ge2 && rd_data[1];
    assign mid = r_s_ge1 && rd_data[0];

    always_comb begin
        o_entry.cur      = r_s_cur;
        o_entry.top      = top;
        o_entry.mid      = mid;
        o_entry.col_zero = r_s_colz;
        o_entry.emit1    = r_s_ge1 && !r_s_colz;
        o_entry.emit2    = r_s_ge1 && r_s_end;
        o_entry.flush    = r_s_flush;
        o_entry.row      = r_s_row10;
        o_entry.col      = r_s_col10;
    end

endmodule
`default_nettype wire

[rtl/core/lcs_queue.sv]
// Short queue of classified items between the front and the back part.
`default_nettype none
module lcs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lcs_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output lcs_pkg::t_entry      o_entry
);
    import lcs_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);

    t_entry         r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QPW:0]   r_cnt;

    assign o_full  = r_cnt == (QPW + 1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPW + 1)'(1);
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/lcs_back.sv]
// Back part: 3x3 window, life rule and result output register.
`default_nettype none
module lcs_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    input  wire lcs_pkg::t_entry           i_entry,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_next_alive,
    output logic [lcs_pkg::POS_W-1:0]      o_cell_row,
    output logic [lcs_pkg::POS_W-1:0]      o_cell_col,
    output logic                           o_frame_last,
    output logic                           o_run_last
);
    import lcs_pkg::*;

    // Shifting drops the oldest column and leaves the newest one empty.
    localparam logic [8:0] WIN_KEEP = 9'h1B6;

    // Conway rule on a window; bit 4 is the center cell.
    function automatic logic life(input logic [8:0] w);
        logic [3:0] n;
        n = 4'(w[0]) + 4'(w[1]) + 4'(w[2]) + 4'(w[3])
          + 4'(w[5]) + 4'(w[6]) + 4'(w[7]) + 4'(w[8]);
        return (n == 4'd3) || ((n == 4'd2) && w[4]);
    endfunction

    logic [8:0]       r_win,   n_win;
    logic             r_pend,  n_pend;
    logic [POS_W-1:0] r_prow,  n_prow;
    logic [POS_W-1:0] r_pcol,  n_pcol;
    logic             r_pflush, n_pflush;
    logic             r_out_valid, n_out_valid;
    logic             r_alive, n_alive;
    logic [POS_W-1:0] r_row,   n_row;
    logic [POS_W-1:0] r_col,   n_col;
    logic             r_flast, n_flast;
    logic             r_rlast, n_rlast;

    logic       can_load;
    logic [8:0] w_base;
    logic [8:0] w_new;
    logic [8:0] w_tail;

    assign can_load = !r_out_valid || i_out_ready;
    assign w_base   = i_entry.col_zero ? 9'd0 : r_win;
    assign w_new    = ((w_base << 1) & WIN_KEEP)
                    | 9'({i_entry.cur, 2'b00, i_entry.mid, 2'b00, i_entry.top});
    assign w_tail   = (r_win << 1) & WIN_KEEP;
    // Items that give no result drain even while the output waits.
    assign o_pop    = i_q_valid && !r_pend && (can_load || !i_entry.emit1);

    // Result selection: the last column's second result goes first.
    always_comb begin
        n_win       = r_win;
        n_pend      = r_pend;
        n_prow      = r_prow;
        n_pcol      = r_pcol;
        n_pflush    = r_pflush;
        n_out_valid = r_out_valid;
        n_alive     = r_alive;
        n_row       = r_row;
        n_col       = r_col;
        n_flast     = r_flast;
        n_rlast     = r_rlast;
        if (r_pend && can_load) begin
            n_out_valid = 1'b1;
            n_alive     = life(w_tail);
            n_row       = r_prow;
            n_col       = r_pcol;
            n_flast     = r_pflush;
            n_rlast     = 1'b1;
            n_pend      = 1'b0;
        end else if (o_pop) begin
            n_win = w_new;
            if (i_entry.emit1) begin
                n_out_valid = 1'b1;
                n_alive     = life(w_new);
                n_row       = i_entry.row;
                n_col       = i_entry.col - POS_W'(1);
                n_flast     = 1'b0;
                n_rlast     = !i_entry.emit2;
                n_pend      = i_entry.emit2;
                n_prow      = i_entry.row;
                n_pcol      = i_entry.col;
                n_pflush    = i_entry.flush;
            end else if (can_load) begin
                n_out_valid = 1'b0;
            end
        end else if (can_load) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state and window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_prow   <= n_prow;
        r_pcol   <= n_pcol;
        r_pflush <= n_pflush;
        r_alive  <= n_alive;
        r_row    <= n_row;
        r_col    <= n_col;
        r_flast  <= n_flast;
        r_rlast  <= n_rlast;
    end

    assign o_out_valid  = r_out_valid;
    assign o_next_alive = r_alive;
    assign o_cell_row   = r_row;
    assign o_cell_col   = r_col;
    assign o_frame_last = r_flast;
    assign o_run_last   = r_rlast;

endmodule
`default_nettype wire
